@@ design/qslerp_pkg.sv @@
// Shared constants, data types and the arctangent table for the slerp core.
package qslerp_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int ROOT_BITS = 16;
	localparam int QUO_BITS = 16;

	localparam logic signed [31:0] HALF_PI_Q29 = 32'sd843314857;
	localparam logic signed [31:0] PI_Q29 = 32'sd1686629713;
	localparam logic signed [31:0] ONE_Q29 = 32'sd536870912;

	localparam logic [14:0] THR_RESET = 15'd32765;
	localparam logic [2:0] ADDR_THR = 3'd0;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} cordic_t;

	typedef struct packed {
		logic [31:0] rem;
		logic [ROOT_BITS-1:0] root;
	} sqrt_t;

	typedef struct packed {
		logic [47:0] rem;
		logic [30:0] den;
		logic [QUO_BITS-1:0] quo;
	} div_t;

	typedef struct packed {
		logic [3:0][15:0] sv;
		logic [3:0][15:0] ev;
		logic [16:0] t;
		logic signed [16:0] d;
		logic pass;
	} side_t;

	typedef struct packed {
		logic [3:0][15:0] sv;
		logic pass;
		logic degen;
		logic [3:0] neg;
		logic [3:0] zero;
		logic [3:0] sat;
	} tail_t;

	function automatic logic signed [31:0] atan_q29(input int i);
		logic signed [31:0] v;
		case (i)
			0: v = 32'sd421657428;
			1: v = 32'sd248918915;
			2: v = 32'sd131521918;
			3: v = 32'sd66762579;
			4: v = 32'sd33510843;
			5: v = 32'sd16771758;
			6: v = 32'sd8387925;
			7: v = 32'sd4194219;
			8: v = 32'sd2097141;
			9: v = 32'sd1048575;
			10: v = 32'sd524288;
			11: v = 32'sd262144;
			12: v = 32'sd131072;
			13: v = 32'sd65536;
			14: v = 32'sd32768;
			15: v = 32'sd16384;
			16: v = 32'sd8192;
			17: v = 32'sd4096;
			18: v = 32'sd2048;
			19: v = 32'sd1024;
			20: v = 32'sd512;
			21: v = 32'sd256;
			22: v = 32'sd128;
			23: v = 32'sd64;
			24: v = 32'sd32;
			25: v = 32'sd16;
			26: v = 32'sd8;
			27: v = 32'sd4;
			28: v = 32'sd2;
			29: v = 32'sd1;
			default: v = 32'sd0;
		endcase
		return v;
	endfunction

endpackage

@@ design/qslerp_sqrt_cell.sv @@
// One bit of the pipelined restoring square root.
module qslerp_sqrt_cell
	import qslerp_pkg::*;
#(
	parameter int BIT = 0
) (
	input  logic  clk,
	input  logic  en,
	input  sqrt_t d_in,
	output sqrt_t d_out
);

	logic [32:0] trial;
	sqrt_t nxt;

	// (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b)
	always_comb begin
		trial = ({17'd0, d_in.root} << (BIT + 1)) + (33'd1 << (2 * BIT));
		nxt = d_in;
		if ({1'b0, d_in.rem} >= trial) begin
			nxt.rem = d_in.rem - trial[31:0];
			nxt.root = d_in.root | (ROOT_BITS'(1) << BIT);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_out <= nxt;
		end
	end

endmodule

@@ design/qslerp_vec_cell.sv @@
// One vectoring CORDIC iteration, drives y toward zero.
module qslerp_vec_cell
	import qslerp_pkg::*;
#(
	parameter int SHIFT = 0
) (
	input  logic    clk,
	input  logic    en,
	input  cordic_t d_in,
	output cordic_t d_out
);

	logic signed [31:0] xs, ys, at;
	cordic_t nxt;

	always_comb begin
		xs = d_in.x >>> SHIFT;
		ys = d_in.y >>> SHIFT;
		at = atan_q29(SHIFT);
		if (d_in.y > 0) begin
			nxt.x = d_in.x + ys;
			nxt.y = d_in.y - xs;
			nxt.z = d_in.z + at;
		end else begin
			nxt.x = d_in.x - ys;
			nxt.y = d_in.y + xs;
			nxt.z = d_in.z - at;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_out <= nxt;
		end
	end

endmodule

@@ design/qslerp_rot_cell.sv @@
// One rotation CORDIC iteration, drives z toward zero.
module qslerp_rot_cell
	import qslerp_pkg::*;
#(
	parameter int SHIFT = 0
) (
	input  logic    clk,
	input  logic    en,
	input  cordic_t d_in,
	output cordic_t d_out
);

	logic signed [31:0] xs, ys, at;
	cordic_t nxt;

	always_comb begin
		xs = d_in.x >>> SHIFT;
		ys = d_in.y >>> SHIFT;
		at = atan_q29(SHIFT);
		if (d_in.z >= 0) begin
			nxt.x = d_in.x - ys;
			nxt.y = d_in.y + xs;
			nxt.z = d_in.z - at;
		end else begin
			nxt.x = d_in.x + ys;
			nxt.y = d_in.y - xs;
			nxt.z = d_in.z + at;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_out <= nxt;
		end
	end

endmodule

@@ design/qslerp_div_cell.sv @@
// One quotient bit of the pipelined restoring divider.
module qslerp_div_cell
	import qslerp_pkg::*;
#(
	parameter int BIT = 0
) (
	input  logic clk,
	input  logic en,
	input  div_t d_in,
	output div_t d_out
);

	logic [47:0] sub;
	div_t nxt;

	always_comb begin
		sub = {17'd0, d_in.den} << BIT;
		nxt = d_in;
		if (d_in.rem >= sub) begin
			nxt.rem = d_in.rem - sub;
			nxt.quo = d_in.quo | (QUO_BITS'(1) << BIT);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_out <= nxt;
		end
	end

endmodule

@@ design/quaternion_slerp_core.sv @@
// Throughput: one beat per cycle while the output is not stalled; all registered stages,
// including the sqrt, CORDIC and divider cells, advance together.
// A stalled output beat holds the whole chain until it is taken.
// Reset clears all valid flags and sets near_one_threshold to 32765.
module quaternion_slerp_core
	import qslerp_pkg::*;
#(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// start_w, start_x, start_y, start_z, end_w, end_x, end_y, end_z, blend, zero pad
	input  logic [151:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// out_w, out_x, out_y, out_z
	output logic [63:0]  m_axis_tdata,
	// passed_start, degenerate
	output logic [1:0]   m_axis_tuser,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int N = CORDIC_STEPS;
	localparam int LAT = ROOT_BITS + QUO_BITS + 12 + 2 * N;
	localparam int SIDE_LEN = ROOT_BITS + 8 + 2 * N;
	localparam int IDX_VINIT = ROOT_BITS + 1;
	localparam int IDX_T = ROOT_BITS + 3 + N;
	localparam int IDX_PROD = ROOT_BITS + 5 + 2 * N;
	localparam int IDX_SUM = ROOT_BITS + 6 + 2 * N;

	logic adv;
	logic [LAT-1:0] vld_q;
	logic [14:0] thr_q;

	side_t in_s1, in_s2, side_new;
	logic signed [31:0] prod_s2 [4];
	side_t side_q [SIDE_LEN];

	logic signed [33:0] dot_sum, dot_rnd, dot_sh, dsq, rad;
	logic signed [16:0] dcl;

	sqrt_t sq_q [ROOT_BITS+1];
	cordic_t vec_q [N+1];
	cordic_t vec_init;
	logic [30:0] theta_q, theta2_q;
	logic [47:0] p1, p2;
	logic [31:0] a1_q, a2_q;
	logic [31:0] ang [3];
	cordic_t rot_q [3][N+1];

	logic signed [47:0] n1_s [4];
	logic signed [47:0] n2_s [4];
	logic signed [31:0] s0_p, s0_n;
	logic signed [47:0] num_q [4];
	logic degen_q;

	div_t div_q [4][QUO_BITS+1];
	div_t div_init [4];
	tail_t tail_q [QUO_BITS+1];
	tail_t tail_new;
	logic [47:0] mag [4];
	logic [15:0] res [4];
	logic [15:0] out_q [4];
	logic pass_out_q, degen_out_q;

	assign adv = !vld_q[LAT-1] || m_axis_tready;
	assign s_axis_tready = adv;
	assign m_axis_tvalid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
		end
	end

	// configuration register
	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_THR) ? {17'd0, thr_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (psel && penable && pwrite && pready && paddr == ADDR_THR) begin
			thr_q <= pwdata[14:0];
		end
	end

	// input unpack, blend clamped to one
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			in_s1.sv[k] = s_axis_tdata[16*k +: 16];
			in_s1.ev[k] = s_axis_tdata[64 + 16*k +: 16];
		end
		in_s1.t = (s_axis_tdata[144:128] > 17'd65536) ? 17'd65536 : s_axis_tdata[144:128];
		in_s1.d = '0;
		in_s1.pass = 1'b0;
	end

	side_t in_q;
	always_ff @(posedge clk) begin
		if (adv) begin
			in_q <= in_s1;
			in_s2 <= in_q;
			for (int k = 0; k < 4; k++) begin
				prod_s2[k] <= $signed(in_q.sv[k]) * $signed(in_q.ev[k]);
			end
		end
	end

	// dot product: round half up, clamp, threshold test
	always_comb begin
		dot_sum = 34'(prod_s2[0]) + 34'(prod_s2[1]) + 34'(prod_s2[2]) + 34'(prod_s2[3]);
		dot_rnd = dot_sum + 34'sd16384;
		dot_sh = dot_rnd >>> 15;
		if (dot_sh > 34'sd32768) begin
			dcl = 17'sd32768;
		end else if (dot_sh < -34'sd32768) begin
			dcl = -17'sd32768;
		end else begin
			dcl = dot_sh[16:0];
		end
		side_new = in_s2;
		side_new.d = dcl;
		side_new.pass = (dcl >= $signed({2'b00, thr_q}));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_q[0] <= side_new;
			for (int j = 1; j < SIDE_LEN; j++) begin
				side_q[j] <= side_q[j-1];
			end
		end
	end

	// radicand 1 - d^2 in Q2.30
	always_comb begin
		dsq = 34'(side_q[0].d) * 34'(side_q[0].d);
		rad = 34'sd1073741824 - dsq;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_q[0].rem <= rad[31:0];
			sq_q[0].root <= '0;
		end
	end

	for (genvar b = 0; b < ROOT_BITS; b++) begin : g_sqrt
		qslerp_sqrt_cell #(.BIT(ROOT_BITS - 1 - b)) u_cell (
			.clk  (clk),
			.en   (adv),
			.d_in (sq_q[b]),
			.d_out(sq_q[b+1])
		);
	end

	// arc cosine: vector (d, sqrt) in Q.29, quarter turn first when d < 0
	always_comb begin
		logic signed [31:0] x0, y0;
		x0 = 32'(side_q[IDX_VINIT].d) <<< 14;
		y0 = $signed({2'b00, sq_q[ROOT_BITS].root, 14'd0});
		if (x0 < 0) begin
			vec_init.x = y0;
			vec_init.y = -x0;
			vec_init.z = HALF_PI_Q29;
		end else begin
			vec_init.x = x0;
			vec_init.y = y0;
			vec_init.z = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vec_q[0] <= vec_init;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_vec
		qslerp_vec_cell #(.SHIFT(i)) u_cell (
			.clk  (clk),
			.en   (adv),
			.d_in (vec_q[i]),
			.d_out(vec_q[i+1])
		);
	end

	// angle clamp, then sub-angles
	always_comb begin
		p1 = 48'(17'(17'd65536 - side_q[IDX_T].t)) * 48'(theta_q);
		p2 = 48'(side_q[IDX_T].t) * 48'(theta_q);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (vec_q[N].z < 0) begin
				theta_q <= '0;
			end else if (vec_q[N].z > PI_Q29) begin
				theta_q <= PI_Q29[30:0];
			end else begin
				theta_q <= vec_q[N].z[30:0];
			end
			theta2_q <= theta_q;
			a1_q <= p1[47:16];
			a2_q <= p2[47:16];
		end
	end

	// fold into [0, pi/2], start rotation from (1, 0)
	always_comb begin
		ang[0] = {1'b0, theta2_q};
		ang[1] = a1_q;
		ang[2] = a2_q;
	end

	for (genvar l = 0; l < 3; l++) begin : g_lane
		always_ff @(posedge clk) begin
			if (adv) begin
				rot_q[l][0].x <= ONE_Q29;
				rot_q[l][0].y <= '0;
				if (ang[l] > $unsigned(HALF_PI_Q29)) begin
					rot_q[l][0].z <= PI_Q29 - $signed(ang[l]);
				end else begin
					rot_q[l][0].z <= $signed(ang[l]);
				end
			end
		end

		for (genvar i = 0; i < N; i++) begin : g_rot
			qslerp_rot_cell #(.SHIFT(i)) u_cell (
				.clk  (clk),
				.en   (adv),
				.d_in (rot_q[l][i]),
				.d_out(rot_q[l][i+1])
			);
		end
	end

	// weighted sum S1*start + S2*end
	always_ff @(posedge clk) begin
		if (adv) begin
			s0_p <= rot_q[0][N].y;
			for (int k = 0; k < 4; k++) begin
				n1_s[k] <= 48'(rot_q[1][N].y) * 48'($signed(side_q[IDX_PROD].sv[k]));
				n2_s[k] <= 48'(rot_q[2][N].y) * 48'($signed(side_q[IDX_PROD].ev[k]));
			end
			s0_n <= s0_p;
			degen_q <= (side_q[IDX_SUM].d == -17'sd32768) || (s0_p <= 0);
			for (int k = 0; k < 4; k++) begin
				num_q[k] <= n1_s[k] + n2_s[k];
			end
		end
	end

	// divider setup: |num| + S0/2, overflow when quotient exceeds 16 bits
	always_comb begin
		tail_new.sv = side_q[SIDE_LEN-1].sv;
		tail_new.pass = side_q[SIDE_LEN-1].pass;
		tail_new.degen = degen_q;
		for (int k = 0; k < 4; k++) begin
			mag[k] = (num_q[k] < 0) ? 48'(-num_q[k]) : 48'(num_q[k]);
			mag[k] = mag[k] + {17'd0, s0_n[31:1]};
			tail_new.neg[k] = num_q[k] < 0;
			tail_new.zero[k] = num_q[k] == 0;
			tail_new.sat[k] = mag[k] >= {1'b0, s0_n[30:0], 16'd0};
			div_init[k].rem = mag[k];
			div_init[k].den = s0_n[30:0];
			div_init[k].quo = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tail_q[0] <= tail_new;
			for (int j = 1; j <= QUO_BITS; j++) begin
				tail_q[j] <= tail_q[j-1];
			end
		end
	end

	for (genvar k = 0; k < 4; k++) begin : g_div
		always_ff @(posedge clk) begin
			if (adv) begin
				div_q[k][0] <= div_init[k];
			end
		end

		for (genvar b = 0; b < QUO_BITS; b++) begin : g_bit
			qslerp_div_cell #(.BIT(QUO_BITS - 1 - b)) u_cell (
				.clk  (clk),
				.en   (adv),
				.d_in (div_q[k][b]),
				.d_out(div_q[k][b+1])
			);
		end
	end

	// result select and saturation
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			logic [QUO_BITS-1:0] q;
			q = div_q[k][QUO_BITS].quo;
			if (tail_q[QUO_BITS].pass) begin
				res[k] = tail_q[QUO_BITS].sv[k];
			end else if (tail_q[QUO_BITS].degen) begin
				if (tail_q[QUO_BITS].zero[k]) begin
					res[k] = 16'h0000;
				end else if (tail_q[QUO_BITS].neg[k]) begin
					res[k] = 16'h8000;
				end else begin
					res[k] = 16'h7FFF;
				end
			end else if (tail_q[QUO_BITS].neg[k]) begin
				if (tail_q[QUO_BITS].sat[k] || q > 16'd32768) begin
					res[k] = 16'h8000;
				end else begin
					res[k] = 16'(-{1'b0, q});
				end
			end else begin
				if (tail_q[QUO_BITS].sat[k] || q > 16'd32767) begin
					res[k] = 16'h7FFF;
				end else begin
					res[k] = q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 4; k++) begin
				out_q[k] <= res[k];
			end
			pass_out_q <= tail_q[QUO_BITS].pass;
			degen_out_q <= !tail_q[QUO_BITS].pass && tail_q[QUO_BITS].degen;
		end
	end

	assign m_axis_tdata = {out_q[3], out_q[2], out_q[1], out_q[0]};
	assign m_axis_tuser = {degen_out_q, pass_out_q};

endmodule

@@ tb/quaternion_slerp_checker.sv @@
// Checker for the slerp core: watches both streams, predicts each result, compares.
module quaternion_slerp_checker
	import qslerp_pkg::*;
#(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [151:0] s_axis_tdata,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [63:0]  m_axis_tdata,
	input  logic [1:0]   m_axis_tuser,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	input  logic         pready,
	output int           fail_count,
	output int           pending
);

	typedef struct packed {
		logic [63:0] comps;
		logic [1:0]  flags;
	} slerp_out_t;

	slerp_out_t expected_q[$];
	logic [14:0] thr;

	function automatic longint fshift(longint v, int s);
		if (v >= 0)
			return v >>> s;
		return -((-(v + 1)) >>> s) - 1;
	endfunction

	function automatic longint isqrt(longint v);
		longint r, b;
		r = 0;
		b = 64'sd1 <<< 62;
		while (b > v)
			b = b >>> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >>> 1) + b;
			end else begin
				r = r >>> 1;
			end
			b = b >>> 2;
		end
		return r;
	endfunction

	function automatic longint acos_q29(longint d);
		longint x, y, z, nx, ny;
		x = d * 16384;
		y = isqrt((64'sd1 <<< 30) - d * d) * 16384;
		z = 0;
		if (x < 0) begin
			nx = y;
			y = -x;
			x = nx;
			z = HALF_PI_Q29;
		end
		for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
			if (y > 0) begin
				nx = x + fshift(y, i);
				ny = y - fshift(x, i);
				z += longint'(atan_q29(i));
			end else begin
				nx = x - fshift(y, i);
				ny = y + fshift(x, i);
				z -= longint'(atan_q29(i));
			end
			x = nx;
			y = ny;
		end
		if (z < 0)
			z = 0;
		if (z > PI_Q29)
			z = PI_Q29;
		return z;
	endfunction

	// unscaled CORDIC sine; the gain cancels in the ratio
	function automatic longint sin_q29(longint a);
		longint x, y, z, nx, ny;
		x = 64'sd1 <<< 29;
		y = 0;
		if (a > HALF_PI_Q29)
			a = PI_Q29 - a;
		z = a;
		for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
			if (z >= 0) begin
				nx = x - fshift(y, i);
				ny = y + fshift(x, i);
				z -= longint'(atan_q29(i));
			end else begin
				nx = x + fshift(y, i);
				ny = y - fshift(x, i);
				z += longint'(atan_q29(i));
			end
			x = nx;
			y = ny;
		end
		return y;
	endfunction

	function automatic slerp_out_t slerp_predict(logic [151:0] bus, logic [14:0] th);
		slerp_out_t r;
		longint sv[4], ev[4], dot, d, t, theta, s0, s1, s2, num, q, res;
		bit degen;
		dot = 0;
		for (int k = 0; k < 4; k++) begin
			sv[k] = longint'($signed(bus[16*k +: 16]));
			ev[k] = longint'($signed(bus[64 + 16*k +: 16]));
			dot += sv[k] * ev[k];
		end
		t = longint'(bus[128 +: 17]);
		if (t > 65536)
			t = 65536;
		d = fshift(dot + 16384, 15);
		if (d > 32768)
			d = 32768;
		if (d < -32768)
			d = -32768;
		if (d >= longint'(th)) begin
			r.comps = bus[63:0];
			r.flags = 2'b01;
			return r;
		end
		theta = acos_q29(d);
		s0 = sin_q29(theta);
		s1 = sin_q29(((65536 - t) * theta) >>> 16);
		s2 = sin_q29((t * theta) >>> 16);
		degen = (d <= -32768) || (s0 <= 0);
		for (int k = 0; k < 4; k++) begin
			num = s1 * sv[k] + s2 * ev[k];
			if (degen) begin
				res = num > 0 ? 32767 : (num < 0 ? -32768 : 0);
			end else begin
				q = ((num < 0 ? -num : num) + s0 / 2) / s0;
				res = num < 0 ? -q : q;
				if (res > 32767)
					res = 32767;
				if (res < -32768)
					res = -32768;
			end
			r.comps[16*k +: 16] = res[15:0];
		end
		r.flags = {degen, 1'b0};
		return r;
	endfunction

	assign pending = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		slerp_out_t e;
		if (!arst_n) begin
			thr <= THR_RESET;
			fail_count <= 0;
			expected_q.delete();
		end else begin
			if (psel && penable && pwrite && pready && paddr == ADDR_THR)
				thr <= pwdata[14:0];
			if (s_axis_tvalid && s_axis_tready)
				expected_q.push_back(slerp_predict(s_axis_tdata, thr));
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_q.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result beat %h/%b", m_axis_tdata, m_axis_tuser);
					fail_count <= fail_count + 1;
				end else begin
					e = expected_q.pop_front();
					if (e.comps !== m_axis_tdata || e.flags !== m_axis_tuser) begin
						if (fail_count < 10)
							$display("mismatch: exp %h/%b got %h/%b",
								e.comps, e.flags, m_axis_tdata, m_axis_tuser);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

@@ tb/quaternion_slerp_core_tb.sv @@
// Stimulus and verdict for the slerp core testbench.
module quaternion_slerp_core_tb;
	import qslerp_pkg::*;

	localparam int LATENCY = 44 + 2 * CORDIC_STEPS_DEF;
	localparam int STALL_LIMIT = 20000;

	logic         clk, arst_n;
	logic         s_axis_tvalid, s_axis_tready;
	logic [151:0] s_axis_tdata;
	logic         m_axis_tvalid, m_axis_tready;
	logic [63:0]  m_axis_tdata;
	logic [1:0]   m_axis_tuser;
	logic         psel, penable, pwrite;
	logic [2:0]   paddr;
	logic [31:0]  pwdata, prdata;
	logic         pready;
	int           fail_count, pending;
	int           idle_cycles;
	bit           calm_out;

	quaternion_slerp_core i_dut (.*);
	quaternion_slerp_checker i_chk (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// sink-side backpressure, calm stretch for a while in the middle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= calm_out || ($urandom_range(99) >= 14);
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			idle_cycles <= 0;
		else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	always @(posedge clk) begin
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic reg_write(logic [14:0] v);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= ADDR_THR;
		pwdata <= {17'd0, v};
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic drain();
		while (pending != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic logic [15:0] rand_comp();
		case ($urandom_range(5))
			0: return 16'h7fff;
			1: return 16'h8000;
			default: return 16'($urandom);
		endcase
	endfunction

	// unit-ish quaternion with random direction
	function automatic logic [63:0] rand_quat();
		real c[4], n;
		logic [63:0] q;
		n = 0;
		for (int k = 0; k < 4; k++) begin
			c[k] = real'($urandom_range(65535)) - 32767.5;
			n += c[k] * c[k];
		end
		n = $sqrt(n);
		for (int k = 0; k < 4; k++)
			q[16*k +: 16] = 16'($rtoi(c[k] / n * 32767.0));
		return q;
	endfunction

	function automatic logic [16:0] rand_blend();
		case ($urandom_range(9))
			0: return 17'd0;
			1: return 17'd65536;
			2: return 17'($urandom_range(131071, 65537));
			default: return 17'($urandom_range(65535));
		endcase
	endfunction

	task automatic send(logic [63:0] sq, logic [63:0] eq, logic [16:0] t, bit gaps);
		while (gaps && $urandom_range(99) < 14) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {7'd0, t, eq, sq};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	task automatic idle_input();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_phase(int n, bit gaps);
		logic [63:0] a, b;
		for (int i = 0; i < n; i++) begin
			a = rand_quat();
			case ($urandom_range(9))
				0: b = {rand_comp(), rand_comp(), rand_comp(), rand_comp()};
				1: b = a;
				2: b = ~a + 64'h0001_0001_0001_0001;
				3: b = a ^ 64'h0003_0001_0002_0001;
				default: b = rand_quat();
			endcase
			if ($urandom_range(9) == 0)
				a = {rand_comp(), rand_comp(), rand_comp(), rand_comp()};
			send(a, b, rand_blend(), gaps);
		end
		idle_input();
	endtask

	localparam logic [63:0] Q_ID = 64'h0000_0000_0000_7fff;
	localparam logic [63:0] Q_NEG = 64'h0000_0000_0000_8001;
	localparam logic [63:0] Q_X = 64'h0000_0000_7fff_0000;
	localparam logic [63:0] Q_MAX = 64'h7fff_7fff_7fff_7fff;
	localparam logic [63:0] Q_MIN = 64'h8000_8000_8000_8000;

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		calm_out = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: pass-through, opposites, orthogonal, extremes, blend ends
		send(Q_ID, Q_ID, 17'd32768, 1'b0);
		send(Q_ID, Q_NEG, 17'd32768, 1'b0);
		send(Q_MIN, Q_MIN, 17'd0, 1'b0);
		send(Q_MAX, Q_MIN, 17'd65536, 1'b0);
		send(Q_ID, Q_X, 17'd0, 1'b0);
		send(Q_ID, Q_X, 17'd65536, 1'b0);
		send(Q_ID, Q_X, 17'h1ffff, 1'b0);
		send(Q_ID, Q_X, 17'd32768, 1'b0);
		send(Q_X, Q_ID, 17'd16384, 1'b0);
		send(Q_MIN, Q_MAX, 17'd1, 1'b0);
		send('0, '0, 17'd40000, 1'b0);
		send(Q_ID, 64'h0000_0000_0080_7ffe, 17'd20000, 1'b0);
		send(64'h5a82_0000_0000_5a82, Q_ID, 17'd50000, 1'b0);
		idle_input();

		// sender holds off until every result is back
		drain();
		random_phase(600, 1'b1);

		drain();
		reg_write(15'd0);
		random_phase(300, 1'b1);

		drain();
		reg_write(15'd32767);
		calm_out = 1'b1;
		random_phase(400, 1'b0);
		calm_out = 1'b0;

		drain();
		reg_write(15'd16384);
		random_phase(300, 1'b1);

		drain();
		reg_write(15'd32765);
		random_phase(400, 1'b1);

		drain();
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

@@ quaternion_slerp_core.f @@
design/qslerp_pkg.sv
design/qslerp_sqrt_cell.sv
design/qslerp_vec_cell.sv
design/qslerp_rot_cell.sv
design/qslerp_div_cell.sv
design/quaternion_slerp_core.sv
tb/quaternion_slerp_checker.sv
tb/quaternion_slerp_core_tb.sv
